/* src/rcp_pkg.sv */
// Package for the roaring container planner: field widths, saturation limits,
// container kind codes, configuration indexes and the shared record types.
// No dependencies.
package rcp_pkg;

	localparam int MEMBER_W = 64;
	localparam int HIGH_W = 32;
	localparam int CKEY_W = 16;
	localparam int LOW_W = 16;
	localparam int COUNT_W = 17;
	localparam int RUNS_W = 16;
	localparam int SIZE_W = 18;
	localparam int PAYLOAD_W = 14;
	localparam int BLOB_W = 30;
	localparam int TOTAL_W = 48;
	localparam int ALIM_W = 17;
	localparam int RTL_W = 18;
	localparam int CFG_DATA_W = 18;
	localparam int OUT_DATA_W = 192;
	localparam int OUT_USER_W = 3;

	localparam logic [COUNT_W-1:0] MAX_COUNT = '1;
	localparam logic [RUNS_W-1:0] MAX_RUNS = '1;
	localparam logic [BLOB_W-1:0] MAX_BLOB = '1;
	localparam logic [TOTAL_W-1:0] MAX_TOTAL = '1;
	localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD = '1;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 48'd8;
	localparam logic [ALIM_W-1:0] ALIM_RESET = 17'd4096;
	localparam logic [RTL_W-1:0] RTL_RESET = 18'd8224;
	localparam logic [SIZE_W-1:0] BITMAP_BYTES = 18'd8192;

	typedef enum logic [1:0] {
		KIND_ARRAY = 2'd0,
		KIND_BITMAP = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	typedef enum logic {
		CFG_ARRAY_LIMIT = 1'b0,
		CFG_RUN_TIE_LIMIT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [HIGH_W-1:0] high;
		logic [CKEY_W-1:0] ckey;
		logic [COUNT_W-1:0] count;
		logic [RUNS_W-1:0] runs;
	} cont_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [BLOB_W-1:0] bodies;
		logic has_runs;
	} grp_t;

	typedef struct packed {
		logic [HIGH_W-1:0] group_key;
		logic [CKEY_W-1:0] cont_key;
		logic [COUNT_W-1:0] member_count;
		logic [RUNS_W-1:0] run_total;
		kind_t container_kind;
		logic [PAYLOAD_W-1:0] payload_bytes;
		logic group_closed;
		logic [COUNT_W-1:0] group_containers;
		logic group_runs_present;
		logic [BLOB_W-1:0] group_blob_bytes;
		logic [TOTAL_W-1:0] running_body_length;
		logic end_of_burst;
	} result_t;

endpackage

/* src/rcp_closer.sv */
// Container close logic: picks the container kind and body size, folds the
// body into the group totals and, when the group ends, works out its blob size.
// Depends on rcp_pkg.
module rcp_closer
	import rcp_pkg::*;
(
	input  cont_t                 cont,
	input  grp_t                  grp,
	input  logic [TOTAL_W-1:0]    total,
	input  logic [ALIM_W-1:0]     array_limit,
	input  logic [RTL_W-1:0]      run_tie_limit,
	input  logic                  group_close,
	output result_t               res,
	output grp_t                  grp_next,
	output logic [TOTAL_W-1:0]    total_next
);

	logic [SIZE_W-1:0] as_run;
	logic [SIZE_W-1:0] as_arr;
	logic [SIZE_W-1:0] size;
	kind_t kind;
	logic [COUNT_W-1:0] cnt;
	logic has_runs;
	logic [BLOB_W:0] bodies_sum;
	logic [BLOB_W-1:0] bodies;
	logic [COUNT_W+1:0] cnt4;
	logic [COUNT_W:0] run_map;
	logic [31:0] blob_sum;
	logic [BLOB_W-1:0] blob;
	logic [TOTAL_W:0] total_sum;
	logic [TOTAL_W-1:0] total_closed;

	always_comb begin
		as_run = SIZE_W'(2) + {cont.runs, 2'b00};
		as_arr = {cont.count, 1'b0};
		if ((as_run < run_tie_limit) && (as_run < as_arr)) begin
			kind = KIND_RUN;
			size = as_run;
		end else if (cont.count <= array_limit) begin
			kind = KIND_ARRAY;
			size = as_arr;
		end else begin
			kind = KIND_BITMAP;
			size = BITMAP_BYTES;
		end

		cnt = (grp.count == MAX_COUNT) ? grp.count : grp.count + COUNT_W'(1);
		has_runs = grp.has_runs || (kind == KIND_RUN);
		bodies_sum = {1'b0, grp.bodies} + (BLOB_W+1)'(size);
		bodies = bodies_sum[BLOB_W] ? MAX_BLOB : bodies_sum[BLOB_W-1:0];

		cnt4 = {cnt, 2'b00};
		run_map = ({1'b0, cnt} + (COUNT_W+1)'(7)) >> 3;
		blob_sum = (has_runs ? 32'd4 : 32'd8) + 32'(cnt4) + 32'(bodies);
		if (has_runs) begin
			blob_sum = blob_sum + 32'(run_map);
		end
		if (!has_runs || (cnt >= COUNT_W'(4))) begin
			blob_sum = blob_sum + 32'(cnt4);
		end
		blob = (blob_sum > 32'(MAX_BLOB)) ? MAX_BLOB : blob_sum[BLOB_W-1:0];

		total_sum = {1'b0, total} + (TOTAL_W+1)'(4) + (TOTAL_W+1)'(blob);
		total_closed = total_sum[TOTAL_W] ? MAX_TOTAL : total_sum[TOTAL_W-1:0];

		if (group_close) begin
			grp_next = '0;
			total_next = total_closed;
		end else begin
			grp_next.count = cnt;
			grp_next.bodies = bodies;
			grp_next.has_runs = has_runs;
			total_next = total;
		end

		res.group_key = cont.high;
		res.cont_key = cont.ckey;
		res.member_count = cont.count;
		res.run_total = cont.runs;
		res.container_kind = kind;
		res.payload_bytes = (size > SIZE_W'(MAX_PAYLOAD)) ? MAX_PAYLOAD
			: size[PAYLOAD_W-1:0];
		res.group_closed = group_close;
		res.group_containers = group_close ? cnt : '0;
		res.group_runs_present = group_close && has_runs;
		res.group_blob_bytes = group_close ? blob : '0;
		res.running_body_length = total_next;
		res.end_of_burst = 1'b0;
	end

endmodule

/* src/rcp_out_queue.sv */
// Two-entry result queue between the planner and the output stream, so a new
// item is taken while an earlier result waits. Depends on rcp_pkg.
module rcp_out_queue
	import rcp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_item,
	output logic    push_ready,
	output logic    pop_valid,
	output result_t pop_item,
	input  logic    pop
);

	result_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign pop_valid = (fill_q != 2'd0);
	assign push_ready = (fill_q != 2'd2) || pop;
	assign do_pop = pop && pop_valid;
	assign do_push = push && push_ready;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* src/roaring_container_planner.sv */
// Top level of the roaring container planner: input register, open container
// and group state, configuration registers. Depends on rcp_pkg, rcp_closer and
// rcp_out_queue.
//
// Members arrive in ascending order, one item per cycle while s_tready is high,
// with tlast on the last member of the set. A member that stays in the open
// container is taken every cycle. Each closed container gives one result item,
// written through a single close unit into a two-entry result queue; an item
// that closes the open container and ends the set waits in the input register
// for its own result. tlast marks the last result caused by an item, and tuser
// holds the container kind and the group-closed flag. Configuration holds its
// value across sets. The user must write it while the block is idle (unchecked).
module roaring_container_planner
	import rcp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// s_tdata: member [63:0]
	input  logic [MEMBER_W-1:0]      s_tdata,
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// m_tdata: group_key [31:0], cont_key [47:32], member_count [64:48],
	// run_total [80:65], payload_bytes [94:81], group_containers [111:95],
	// group_runs_present [112], group_blob_bytes [142:113],
	// running_body_length [190:143], zero [191]
	output logic [OUT_DATA_W-1:0]    m_tdata,
	// m_tuser: container_kind [1:0], group_closed [2]
	output logic [OUT_USER_W-1:0]    m_tuser,
	output logic                     m_tlast
);

	logic valid_s1;
	logic [MEMBER_W-1:0] member_s1;
	logic final_s1;

	logic [ALIM_W-1:0] array_limit_q;
	logic [RTL_W-1:0] run_tie_limit_q;

	logic active_q;
	cont_t open_q;
	logic [LOW_W-1:0] prior_low_q;
	grp_t grp_q;
	logic [TOTAL_W-1:0] total_q;

	logic [HIGH_W-1:0] in_high;
	logic [CKEY_W-1:0] in_ckey;
	logic [LOW_W-1:0] in_low;
	logic high_differs;
	logic differ;
	cont_t merged;
	cont_t close_cont;
	logic close_group;
	logic emit;
	logic fire;
	logic consume;
	result_t close_res;
	result_t push_item;
	grp_t grp_next;
	logic [TOTAL_W-1:0] total_next;
	logic push_ready;
	logic pop_valid;
	result_t pop_item;

	assign in_high = member_s1[63:32];
	assign in_ckey = member_s1[31:16];
	assign in_low = member_s1[15:0];

	always_comb begin
		high_differs = (in_high != open_q.high);
		differ = active_q && (high_differs || (in_ckey != open_q.ckey));

		merged.high = in_high;
		merged.ckey = in_ckey;
		if (active_q) begin
			merged.count = (open_q.count == MAX_COUNT) ? open_q.count
				: open_q.count + COUNT_W'(1);
			if (({1'b0, in_low} != ({1'b0, prior_low_q} + 17'd1))
				&& (open_q.runs != MAX_RUNS)) begin
				merged.runs = open_q.runs + RUNS_W'(1);
			end else begin
				merged.runs = open_q.runs;
			end
		end else begin
			merged.count = COUNT_W'(1);
			merged.runs = RUNS_W'(1);
		end

		close_cont = differ ? open_q : merged;
		close_group = differ ? high_differs : 1'b1;

		emit = valid_s1 && (differ || final_s1);
		fire = valid_s1 && (!emit || push_ready);
		consume = fire && !(differ && final_s1);

		push_item = close_res;
		push_item.end_of_burst = !(differ && final_s1);
	end

	assign s_tready = !valid_s1 || consume;

	rcp_closer u_closer (
		.cont          (close_cont),
		.grp           (grp_q),
		.total         (total_q),
		.array_limit   (array_limit_q),
		.run_tie_limit (run_tie_limit_q),
		.group_close   (close_group),
		.res           (close_res),
		.grp_next      (grp_next),
		.total_next    (total_next)
	);

	rcp_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit && fire),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (m_tready)
	);

	assign m_tvalid = pop_valid;
	assign m_tlast = pop_item.end_of_burst;
	assign m_tuser = {pop_item.group_closed, pop_item.container_kind};
	assign m_tdata = {1'b0,
		pop_item.running_body_length,
		pop_item.group_blob_bytes,
		pop_item.group_runs_present,
		pop_item.group_containers,
		pop_item.payload_bytes,
		pop_item.run_total,
		pop_item.member_count,
		pop_item.cont_key,
		pop_item.group_key};

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			member_s1 <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_limit_q <= ALIM_RESET;
			run_tie_limit_q <= RTL_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_ARRAY_LIMIT: array_limit_q <= cfg_data[ALIM_W-1:0];
				CFG_RUN_TIE_LIMIT: run_tie_limit_q <= cfg_data[RTL_W-1:0];
				default: array_limit_q <= array_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			open_q <= '0;
			prior_low_q <= '0;
			grp_q <= '0;
			total_q <= TOTAL_RESET;
		end else if (fire) begin
			if (differ) begin
				grp_q <= grp_next;
				total_q <= total_next;
				if (final_s1) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					open_q.high <= in_high;
					open_q.ckey <= in_ckey;
					open_q.count <= COUNT_W'(1);
					open_q.runs <= RUNS_W'(1);
					prior_low_q <= in_low;
				end
			end else if (final_s1) begin
				active_q <= 1'b0;
				open_q <= '0;
				prior_low_q <= '0;
				grp_q <= '0;
				total_q <= TOTAL_RESET;
			end else begin
				active_q <= 1'b1;
				open_q <= merged;
				prior_low_q <= in_low;
			end
		end
	end

endmodule
